### hw/rtl/fdf_pkg.sv
`timescale 1ns / 1ps

package fdf_pkg;

  // filter length, one cell per tap
  localparam int unsigned TAPS = 32;

  // sample and coefficient format, q1.15
  localparam int unsigned DATA_W = 16;
  localparam int unsigned FRAC_W = 15;
  localparam int unsigned PROD_W = 2 * DATA_W;

  // exact accumulator: product width plus growth over all taps
  localparam int unsigned ACC_W = PROD_W + $clog2(TAPS);

  // configuration register
  localparam int unsigned TAPS_CFG_W = 6;
  localparam logic [TAPS_CFG_W-1:0] ACTIVE_TAPS_RST = TAPS_CFG_W'(32);

  // coefficient index field
  localparam int unsigned COEF_IDX_W = 5;

  // request opcodes, the fourth code is taken and ignored
  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_LOAD   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  // per-cell control strobes
  typedef struct packed {
    logic load;
    logic clear;
    logic shift;
  } cell_ctrl_t;

endpackage

### hw/rtl/fir_direct_form_filter.sv
`timescale 1ns / 1ps
// sample request: start_q registers the acceptance, then the partial sum walks
// the row of tap cells one cell per cycle into the output register; requests
// stall while busy or a held result is stalled; load and clear do not set busy
// reset: asynchronous, active low; coefficients and delay line cleared,
// active_taps set to 32, no result pending
module fir_direct_form_filter import fdf_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   op_i,
  input  logic signed [DATA_W-1:0]     sample_in_i,
  input  logic [COEF_IDX_W-1:0]        coef_index_i,
  input  logic signed [DATA_W-1:0]     coef_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [DATA_W-1:0]     filtered_o,
  output logic                         saturated_o,
  input  logic                         cfg_we_i,
  input  logic [TAPS_CFG_W-1:0]        cfg_wdata_i
);

  localparam int unsigned DONE_DLY = TAPS + 1;

  logic [TAPS_CFG_W-1:0]    active_taps_q;
  logic                     busy_q;
  logic                     start_q;
  logic                     accept;
  logic                     acc_sample;
  logic                     acc_load;
  logic                     acc_clear;
  logic                     done;

  cell_ctrl_t               ctrl   [TAPS];
  logic                     tap_en [TAPS];
  logic signed [DATA_W-1:0] tap    [TAPS];
  logic signed [ACC_W-1:0]  sum    [TAPS];
  logic [TAPS-1:0]          sum_vld;

  // request decode
  assign in_stall_o = busy_q || (out_valid_o && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign acc_sample = accept && (op_i == OP_SAMPLE);
  assign acc_load   = accept && (op_i == OP_LOAD);
  assign acc_clear  = accept && (op_i == OP_CLEAR);
  assign done       = sum_vld[TAPS-1];

  // configuration and sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_taps_q <= ACTIVE_TAPS_RST;
      busy_q        <= 1'b0;
      start_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        active_taps_q <= cfg_wdata_i;
      end
      start_q <= acc_sample;
      if (acc_sample) begin
        busy_q <= 1'b1;
      end else if (done) begin
        busy_q <= 1'b0;
      end
    end
  end

  // row of tap cells; cell 0 takes the new sample, the rest shift at the end
  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    assign tap_en[k]     = (int'(active_taps_q) > k);
    assign ctrl[k].load  = acc_load && (int'(coef_index_i) == k);
    assign ctrl[k].clear = acc_clear;
    if (k == 0) begin : g_head
      assign ctrl[k].shift = acc_sample;
      fdf_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctrl_i      (ctrl[k]),
        .coef_i      (coef_value_i),
        .sample_i    (sample_in_i),
        .tap_en_i    (tap_en[k]),
        .sum_i       ('0),
        .sum_valid_i (start_q),
        .tap_o       (tap[k]),
        .sum_o       (sum[k]),
        .sum_valid_o (sum_vld[k])
      );
    end else begin : g_body
      assign ctrl[k].shift = done;
      fdf_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctrl_i      (ctrl[k]),
        .coef_i      (coef_value_i),
        .sample_i    (tap[k-1]),
        .tap_en_i    (tap_en[k]),
        .sum_i       (sum[k-1]),
        .sum_valid_i (sum_vld[k-1]),
        .tap_o       (tap[k]),
        .sum_o       (sum[k]),
        .sum_valid_o (sum_vld[k])
      );
    end
  end

  // rounding, saturation and output register
  fdf_round_sat u_round_sat (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (sum[TAPS-1]),
    .acc_valid_i (done),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .filtered_o  (filtered_o),
    .saturated_o (saturated_o)
  );

  // only one partial sum in the row at a time
  a_one_sum : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(sum_vld))
    else $error("more than one partial sum in the cell row");

  // a sample finishes a fixed number of cycles after acceptance
  a_done_time : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_sample |-> ##DONE_DLY done)
    else $error("sample did not complete on time");

  // finished sum never lands on a held result
  a_out_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> !out_valid_o)
    else $error("result overwritten in output register");

  // sequencer idles after completion
  a_idle_after : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> !busy_q && out_valid_o)
    else $error("sequencer still busy after completion");

endmodule

### hw/rtl/fdf_cell.sv
`timescale 1ns / 1ps

module fdf_cell import fdf_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cell_ctrl_t               ctrl_i,
  input  logic signed [DATA_W-1:0] coef_i,
  input  logic signed [DATA_W-1:0] sample_i,
  input  logic                     tap_en_i,
  input  logic signed [ACC_W-1:0]  sum_i,
  input  logic                     sum_valid_i,
  output logic signed [DATA_W-1:0] tap_o,
  output logic signed [ACC_W-1:0]  sum_o,
  output logic                     sum_valid_o
);

  logic signed [DATA_W-1:0] coef_q;
  logic signed [DATA_W-1:0] tap_q;
  logic                     sum_valid_q;
  logic signed [ACC_W-1:0]  sum_q;
  logic signed [ACC_W-1:0]  sum_d;
  logic signed [PROD_W-1:0] prod;

  // coefficient and delay-line sample held in this cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q      <= '0;
      tap_q       <= '0;
      sum_valid_q <= 1'b0;
    end else begin
      sum_valid_q <= sum_valid_i;
      if (ctrl_i.load) begin
        coef_q <= coef_i;
      end
      if (ctrl_i.clear) begin
        tap_q <= '0;
      end else if (ctrl_i.shift) begin
        tap_q <= sample_i;
      end
    end
  end

  // multiply-accumulate onto the partial sum passing through, in enabled taps only
  always_comb begin
    prod  = coef_q * tap_q;
    sum_d = tap_en_i ? (sum_i + ACC_W'(prod)) : sum_i;
  end

  always_ff @(posedge clk_i) begin
    if (sum_valid_i) begin
      sum_q <= sum_d;
    end
  end

  assign tap_o       = tap_q;
  assign sum_o       = sum_q;
  assign sum_valid_o = sum_valid_q;

endmodule

### hw/rtl/fdf_round_sat.sv
`timescale 1ns / 1ps

module fdf_round_sat import fdf_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic signed [ACC_W-1:0]  acc_i,
  input  logic                     acc_valid_i,
  input  logic                     out_stall_i,
  output logic                     out_valid_o,
  output logic signed [DATA_W-1:0] filtered_o,
  output logic                     saturated_o
);

  localparam int unsigned R_W = ACC_W + 1;
  localparam int unsigned Q_W = R_W - FRAC_W;
  localparam logic signed [R_W-1:0] HALF  = R_W'(1) <<< (FRAC_W - 1);
  localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(32767);
  localparam logic signed [Q_W-1:0] Q_MIN = ~Q_MAX;

  logic signed [R_W-1:0]    rnd;
  logic signed [Q_W-1:0]    quo;
  logic signed [DATA_W-1:0] filtered_d;
  logic                     saturated_d;
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] filtered_q;
  logic                     saturated_q;

  // round half up, floor shift, clip to 16 bits
  always_comb begin
    rnd = R_W'(acc_i) + HALF;
    quo = Q_W'(rnd >>> FRAC_W);
    if (quo > Q_MAX) begin
      filtered_d  = DATA_W'(Q_MAX);
      saturated_d = 1'b1;
    end else if (quo < Q_MIN) begin
      filtered_d  = DATA_W'(Q_MIN);
      saturated_d = 1'b1;
    end else begin
      filtered_d  = DATA_W'(quo);
      saturated_d = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (acc_valid_i) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_valid_i) begin
      filtered_q  <= filtered_d;
      saturated_q <= saturated_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = filtered_q;
  assign saturated_o = saturated_q;

endmodule
